// ===== rtl/modexp_pkg.sv =====
// Shared widths, counter limits and controller/datapath command and status structs for modular exponentiation.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

    // Operand and product widths
    localparam int OPERAND_WIDTH = 32;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;

    // Counter widths: reduction steps over the product, exponent bit index
    localparam int RED_CNT_W = $clog2(PROD_WIDTH);
    localparam int EXP_CNT_W = $clog2(OPERAND_WIDTH);

    localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(PROD_WIDTH - 1);
    localparam logic [EXP_CNT_W-1:0] EXP_LAST = EXP_CNT_W'(OPERAND_WIDTH - 1);

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load;       // capture operands, seed running value
        logic mul_sq;     // product <= y * y
        logic mul_base;   // product <= y * base
        logic red_step;   // one restoring reduction step
        logic wr_base;    // with red_step: store remainder into base
        logic wr_y;       // with red_step: store remainder into y
        logic exp_shift;  // move to the next exponent bit
    } t_dp_cmd;

    // Datapath status seen by the controller
    typedef struct packed {
        logic mod_zero;   // captured modulus was zero
        logic exp_msb;    // current exponent bit
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/modexp_datapath.sv =====
// Datapath: operand registers, registered multiplier and bit-serial modular reduction.
`timescale 1ns / 1ps
`default_nettype none

module modexp_datapath
    import modexp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [OPERAND_WIDTH-1:0] i_base,
    input  wire logic [OPERAND_WIDTH-1:0] i_exponent,
    input  wire logic [OPERAND_WIDTH-1:0] i_modulus,
    output t_dp_status                    o_status,
    output logic [OPERAND_WIDTH-1:0]      o_power_result,
    output logic                          o_zero_modulus
);

    logic [OPERAND_WIDTH-1:0] r_base;
    logic [OPERAND_WIDTH-1:0] r_exp;
    logic [OPERAND_WIDTH-1:0] r_mod;
    logic [OPERAND_WIDTH-1:0] r_y;
    logic [OPERAND_WIDTH-1:0] r_rem;
    logic [PROD_WIDTH-1:0]    r_prod;
    logic                     r_zero;

    logic [OPERAND_WIDTH:0]   n_trial;
    logic [OPERAND_WIDTH-1:0] n_rem;
    logic [OPERAND_WIDTH-1:0] n_mul_b;

    // Shift the next product bit into the remainder, subtract modulus once if it fits
    always_comb begin
        n_trial = {r_rem, r_prod[PROD_WIDTH-1]};
        if (n_trial >= {1'b0, r_mod}) begin
            n_rem = OPERAND_WIDTH'(n_trial - {1'b0, r_mod});
        end else begin
            n_rem = n_trial[OPERAND_WIDTH-1:0];
        end
    end

    // Select the second multiplier operand
    assign n_mul_b = i_cmd.mul_base ? r_base : r_y;

    // Hold operands and advance the datapath on command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base;
            r_exp  <= i_exponent;
            r_mod  <= i_modulus;
            r_zero <= (i_modulus == '0);
            r_y    <= (i_modulus > OPERAND_WIDTH'(1)) ? OPERAND_WIDTH'(1) : '0;
            r_prod <= {{OPERAND_WIDTH{1'b0}}, i_base};
            r_rem  <= '0;
        end else begin
            if (i_cmd.mul_sq || i_cmd.mul_base) begin
                r_prod <= PROD_WIDTH'(r_y) * PROD_WIDTH'(n_mul_b);
                r_rem  <= '0;
            end
            if (i_cmd.red_step) begin
                r_prod <= {r_prod[PROD_WIDTH-2:0], 1'b0};
                r_rem  <= n_rem;
                if (i_cmd.wr_base) begin
                    r_base <= n_rem;
                end
                if (i_cmd.wr_y) begin
                    r_y <= n_rem;
                end
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {r_exp[OPERAND_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_status          = '{mod_zero: r_zero, exp_msb: r_exp[OPERAND_WIDTH-1]};
    assign o_power_result    = r_y;
    assign o_zero_modulus    = r_zero;

endmodule

`default_nettype wire

// ===== rtl/modexp_ctrl.sv =====
// Controller: sequences base reduction, square and multiply steps over the exponent bits.
`timescale 1ns / 1ps
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            busy,
    output logic            o_done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOADED,
        ST_RED_BASE,
        ST_SQ_MUL,
        ST_SQ_RED,
        ST_BM_MUL,
        ST_BM_RED,
        ST_FINISH
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [RED_CNT_W-1:0]  r_red_cnt;
    logic [RED_CNT_W-1:0]  n_red_cnt;
    logic [EXP_CNT_W-1:0]  r_exp_cnt;
    logic [EXP_CNT_W-1:0]  n_exp_cnt;
    logic                  r_busy;
    logic                  n_busy;
    logic                  r_done;
    logic                  n_done;
    logic                  red_last;

    assign red_last = (r_red_cnt == RED_LAST);

    // Decode commands and next state
    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_red_cnt = r_red_cnt;
        n_exp_cnt = r_exp_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_busy     = 1'b1;
                    n_state    = ST_LOADED;
                end
            end
            ST_LOADED: begin
                n_red_cnt = '0;
                n_exp_cnt = EXP_LAST;
                if (i_status.mod_zero) begin
                    n_done  = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_RED_BASE;
                end
            end
            ST_RED_BASE: begin
                o_cmd.red_step = 1'b1;
                o_cmd.wr_base  = red_last;
                n_red_cnt      = r_red_cnt + 1'b1;
                if (red_last) begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                o_cmd.mul_sq = 1'b1;
                n_red_cnt    = '0;
                n_state      = ST_SQ_RED;
            end
            ST_BM_MUL: begin
                o_cmd.mul_base = 1'b1;
                n_red_cnt      = '0;
                n_state        = ST_BM_RED;
            end
            ST_SQ_RED, ST_BM_RED: begin
                o_cmd.red_step = 1'b1;
                o_cmd.wr_y     = red_last;
                n_red_cnt      = r_red_cnt + 1'b1;
                if (red_last) begin
                    if (r_state == ST_SQ_RED && i_status.exp_msb) begin
                        n_state = ST_BM_MUL;
                    end else begin
                        // Advance to the next exponent bit or finish
                        o_cmd.exp_shift = 1'b1;
                        if (r_exp_cnt == '0) begin
                            n_done  = 1'b1;
                            n_state = ST_FINISH;
                        end else begin
                            n_exp_cnt = r_exp_cnt - 1'b1;
                            n_state   = ST_SQ_MUL;
                        end
                    end
                end
            end
            ST_FINISH: begin
                n_busy  = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_busy  = 1'b0;
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_red_cnt <= '0;
            r_exp_cnt <= '0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_red_cnt <= n_red_cnt;
            r_exp_cnt <= n_exp_cnt;
            r_busy    <= n_busy;
            r_done    <= n_done;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Top level: modular exponentiation by left-to-right square and multiply.
`timescale 1ns / 1ps
`default_nettype none

// Computes base^exponent mod modulus for 32-bit unsigned operands. A word is taken
// when start is high while busy is low; busy then stays high until the result has
// been shown. The result on o_power_result and o_zero_modulus is marked by o_done,
// which is high for exactly one cycle, and must be captured in that cycle; the outputs
// hold it only until the next word is accepted. A zero modulus gives o_zero_modulus = 1
// and a result of 0, with o_done raised straight after the load step and no reduction.
// Otherwise the run time is set by the reduction unit, which folds the 64-bit product
// into the remainder one bit per cycle, once for the base and once for every square and
// every multiply. All exponent bits are scanned, leading zeros included, so timing
// depends only on the number of one bits in the exponent.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OPERAND_WIDTH-1:0] i_base,
    input  wire logic [OPERAND_WIDTH-1:0] i_exponent,
    input  wire logic [OPERAND_WIDTH-1:0] i_modulus,
    output logic                          o_done,
    output logic [OPERAND_WIDTH-1:0]      o_power_result,
    output logic                          o_zero_modulus
);

    t_dp_cmd    cmd;
    t_dp_status status;

    modexp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    modexp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .i_modulus      (i_modulus),
        .o_status       (status),
        .o_power_result (o_power_result),
        .o_zero_modulus (o_zero_modulus)
    );

    // A result is only shown while a word is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe without a word in flight");

    // Each word yields a single one-cycle strobe
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A zero modulus reports a zero result
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_modulus) |-> (o_power_result == '0))
        else $error("zero modulus with nonzero result");

endmodule

`default_nettype wire
